// File: hdl/gdpt_pkg.sv
`default_nettype none

package gdpt_pkg;

	// Door state, one-hot inside the block.
	typedef enum logic [4:0] {
		DOOR_CLOSED  = 5'b00001,
		DOOR_CLOSING = 5'b00010,
		DOOR_OPEN    = 5'b00100,
		DOOR_OPENING = 5'b01000,
		DOOR_STUCK   = 5'b10000
	} door_state_t;

	// Door codes as they appear on the result channel.
	localparam logic [2:0] DOOR_CODE_CLOSED  = 3'd0;
	localparam logic [2:0] DOOR_CODE_CLOSING = 3'd1;
	localparam logic [2:0] DOOR_CODE_OPEN    = 3'd2;
	localparam logic [2:0] DOOR_CODE_OPENING = 3'd3;
	localparam logic [2:0] DOOR_CODE_STUCK   = 3'd4;

	// Command codes; the remaining codes act as no command.
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_OPEN     = 3'd1;
	localparam logic [2:0] CMD_CLOSE    = 3'd2;
	localparam logic [2:0] CMD_STOP     = 3'd3;
	localparam logic [2:0] CMD_OVERRIDE = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_BOUNCE_MS   = 2'd0;
	localparam logic [1:0] REG_MAX_MOVE_MS = 2'd1;
	localparam logic [1:0] REG_PULSE_MS    = 2'd2;

	localparam int unsigned CFG_WIDTH = 16;
	localparam int unsigned IDX_WIDTH = 2;
	localparam int unsigned SINCE_WIDTH = 17;

	localparam logic [CFG_WIDTH-1:0] BOUNCE_MS_RESET   = 16'd1000;
	localparam logic [CFG_WIDTH-1:0] MAX_MOVE_MS_RESET = 16'd30000;
	localparam logic [CFG_WIDTH-1:0] PULSE_MS_RESET    = 16'd500;

	localparam logic [SINCE_WIDTH-1:0] SINCE_MAX = 17'd131071;

	// Maps the internal door state onto its external code.
	function automatic logic [2:0] door_code(door_state_t s);
		logic [2:0] c;
		case (s)
			DOOR_CLOSED:  c = DOOR_CODE_CLOSED;
			DOOR_CLOSING: c = DOOR_CODE_CLOSING;
			DOOR_OPEN:    c = DOOR_CODE_OPEN;
			DOOR_OPENING: c = DOOR_CODE_OPENING;
			DOOR_STUCK:   c = DOOR_CODE_STUCK;
			default:      c = DOOR_CODE_CLOSED;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/gdpt_if.sv
`default_nettype none

// Tick channel: one transaction per millisecond tick.
interface gdpt_tick_if;
	logic       valid;
	logic       ready;
	logic       closed_limit;
	logic       open_limit;
	logic [2:0] command;
	logic       armed;
	logic       anyone_home;

	modport source (output valid, closed_limit, open_limit, command, armed, anyone_home,
		input ready);
	modport sink (input valid, closed_limit, open_limit, command, armed, anyone_home,
		output ready);
endinterface

// Result channel: one transaction per accepted tick.
interface gdpt_result_if;
	logic       valid;
	logic       ready;
	logic       relay;
	logic [2:0] door;
	logic       state_changed;
	logic       stuck_alarm;
	logic       locked;
	logic       lock_changed;
	logic       open_refused;

	modport source (output valid, relay, door, state_changed, stuck_alarm, locked,
		lock_changed, open_refused, input ready);
	modport sink (input valid, relay, door, state_changed, stuck_alarm, locked,
		lock_changed, open_refused, output ready);
endinterface

`default_nettype wire

// File: hdl/garage_door_position_tracker_top.sv
// Garage door position tracker.
// The ticks channel carries one transaction per millisecond: the two
// active-low limit sensors, a door command and the armed and presence levels.
// Each accepted tick yields exactly one transaction on the results channel
// with the relay level, door state, change and alarm flags and lock state.
// The tick is evaluated against the tracker state in the cycle it is
// accepted; the result is registered and offered in the next cycle.
// A new tick is taken every cycle while the receiver takes each result, so
// throughput is one tick per clock, set by the single result register.
// When the receiver stalls, the result register holds its transaction and
// ticks are refused until it is taken; a result taken in the same cycle
// lets the next tick in without a bubble.
// The configuration port writes bounce_ms, max_move_ms and pulse_ms by
// index; the user must write it only while no tick is in flight, which the block does not enforce.
// Reset (arst_n low) sets the door to closed, the settle counter and relay
// pulse to zero, the lock to locked, the registers to their defaults
// (1000, 30000 and 500 ticks) and empties the result register.
`default_nettype none

module garage_door_position_tracker_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	gdpt_tick_if.sink                             ticks,
	gdpt_result_if.source                         results,
	input  wire logic                             wr_en,
	input  wire logic [gdpt_pkg::IDX_WIDTH-1:0]   wr_index,
	input  wire logic [gdpt_pkg::CFG_WIDTH-1:0]   wr_data
);

	localparam int unsigned SW = gdpt_pkg::SINCE_WIDTH;
	localparam int unsigned CW = gdpt_pkg::CFG_WIDTH;

	logic [CW-1:0] bounce_ms_q;
	logic [CW-1:0] max_move_ms_q;
	logic [CW-1:0] pulse_ms_q;

	gdpt_pkg::door_state_t door_q;
	logic [SW-1:0]         since_q;
	logic                  lock_q;
	logic [CW-1:0]         pulse_q;

	logic                  out_valid_q;
	logic                  relay_q;
	logic [2:0]            door_out_q;
	logic                  state_changed_q;
	logic                  stuck_alarm_q;
	logic                  locked_q;
	logic                  lock_changed_q;
	logic                  open_refused_q;

	logic                  accept;
	logic [SW-1:0]         since_inc;
	gdpt_pkg::door_state_t target;
	gdpt_pkg::door_state_t door_a;
	logic [SW-1:0]         since_a;
	logic                  stuck;
	gdpt_pkg::door_state_t door_n;
	logic                  lock_n;
	logic [CW-1:0]         pulse_dec;
	logic                  cmd_take;
	logic                  refused;
	logic [CW-1:0]         pulse_n;

	// A tick enters when the result register is empty or being drained.
	assign ticks.ready = !out_valid_q || results.ready;
	assign accept      = ticks.valid && ticks.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_ms_q   <= gdpt_pkg::BOUNCE_MS_RESET;
			max_move_ms_q <= gdpt_pkg::MAX_MOVE_MS_RESET;
			pulse_ms_q    <= gdpt_pkg::PULSE_MS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				gdpt_pkg::REG_BOUNCE_MS:   bounce_ms_q   <= wr_data;
				gdpt_pkg::REG_MAX_MOVE_MS: max_move_ms_q <= wr_data;
				gdpt_pkg::REG_PULSE_MS:    pulse_ms_q    <= wr_data;
				default: ;
			endcase
		end
	end

	// Settle counter advances by one and saturates.
	assign since_inc = (since_q != gdpt_pkg::SINCE_MAX) ? since_q + 1'b1 : since_q;

	// Sensor rule: where the limit sensors say the door should be.
	always_comb begin
		target = door_q;
		if (door_q != gdpt_pkg::DOOR_OPENING && !ticks.closed_limit
				&& ticks.open_limit) begin
			target = gdpt_pkg::DOOR_CLOSED;
		end else if (door_q != gdpt_pkg::DOOR_CLOSING && ticks.closed_limit
				&& !ticks.open_limit) begin
			target = gdpt_pkg::DOOR_OPEN;
		end else if (door_q != gdpt_pkg::DOOR_STUCK && ticks.closed_limit
				&& ticks.open_limit) begin
			if (door_q == gdpt_pkg::DOOR_OPEN) begin
				target = gdpt_pkg::DOOR_CLOSING;
			end else if (door_q == gdpt_pkg::DOOR_CLOSED) begin
				target = gdpt_pkg::DOOR_OPENING;
			end
		end
	end

	// Accept the sensor change once the bounce time has passed, then check
	// whether a move has run too long.
	always_comb begin
		if (target != door_q && since_inc > {1'b0, bounce_ms_q}) begin
			door_a  = target;
			since_a = '0;
		end else begin
			door_a  = door_q;
			since_a = since_inc;
		end
		stuck  = (door_a == gdpt_pkg::DOOR_CLOSING || door_a == gdpt_pkg::DOOR_OPENING)
			&& since_a > {1'b0, max_move_ms_q};
		door_n = stuck ? gdpt_pkg::DOOR_STUCK : door_a;
	end

	// Lock follows armed or nobody home.
	assign lock_n = ticks.armed || !ticks.anyone_home;

	// Relay pulse counts down; the command is judged on the updated state.
	assign pulse_dec = (pulse_q != '0) ? pulse_q - 1'b1 : pulse_q;

	always_comb begin
		cmd_take = 1'b0;
		refused  = 1'b0;
		case (ticks.command)
			gdpt_pkg::CMD_OPEN: begin
				if (door_n != gdpt_pkg::DOOR_OPEN) begin
					if (lock_n) begin
						refused = 1'b1;
					end else begin
						cmd_take = 1'b1;
					end
				end
			end
			gdpt_pkg::CMD_CLOSE: cmd_take = (door_n != gdpt_pkg::DOOR_CLOSED);
			gdpt_pkg::CMD_STOP: begin
				cmd_take = (door_n == gdpt_pkg::DOOR_OPENING)
					|| (door_n == gdpt_pkg::DOOR_CLOSING);
			end
			gdpt_pkg::CMD_OVERRIDE: cmd_take = 1'b1;
			default: cmd_take = 1'b0;
		endcase
	end

	assign pulse_n = cmd_take ? pulse_ms_q : pulse_dec;

	// Tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q  <= gdpt_pkg::DOOR_CLOSED;
			since_q <= '0;
			lock_q  <= 1'b1;
			pulse_q <= '0;
		end else if (accept) begin
			door_q  <= door_n;
			since_q <= since_a;
			lock_q  <= lock_n;
			pulse_q <= pulse_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			relay_q         <= (pulse_n != '0);
			door_out_q      <= gdpt_pkg::door_code(door_n);
			state_changed_q <= (door_n != door_q);
			stuck_alarm_q   <= stuck;
			locked_q        <= lock_n;
			lock_changed_q  <= (lock_n != lock_q);
			open_refused_q  <= refused;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.relay         = relay_q;
	assign results.door          = door_out_q;
	assign results.state_changed = state_changed_q;
	assign results.stuck_alarm   = stuck_alarm_q;
	assign results.locked        = locked_q;
	assign results.lock_changed  = lock_changed_q;
	assign results.open_refused  = open_refused_q;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASE_TICKS = 70;
	localparam int RANDOM_PHASES = 7;

	// One millisecond tick as it goes into the tracker.
	typedef struct packed {
		logic       front;
		logic       rear;
		logic [2:0] cmd;
		logic       armed;
		logic       home;
	} tick_t;

	// One door report as it comes out of the tracker.
	typedef struct packed {
		logic       relay;
		logic [2:0] door;
		logic       state_changed;
		logic       stuck_alarm;
		logic       locked;
		logic       lock_changed;
		logic       open_refused;
	} door_report_t;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [gdpt_pkg::IDX_WIDTH-1:0] wr_index;
	logic [gdpt_pkg::CFG_WIDTH-1:0] wr_data;

	gdpt_tick_if   tick_ch ();
	gdpt_result_if report_ch ();

	garage_door_position_tracker_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ticks    (tick_ch),
		.results  (report_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Tracker state and register copies kept on the testbench side.
	logic [2:0]                       trk_door;
	logic [gdpt_pkg::SINCE_WIDTH-1:0] trk_since;
	logic                             trk_lock;
	logic [gdpt_pkg::CFG_WIDTH-1:0]   trk_pulse;
	logic [gdpt_pkg::CFG_WIDTH-1:0]   bounce_ticks;
	logic [gdpt_pkg::CFG_WIDTH-1:0]   max_move_ticks;
	logic [gdpt_pkg::CFG_WIDTH-1:0]   pulse_ticks;

	door_report_t door_reports_due[$];

	int error_count;
	int ticks_sent;
	int reports_checked;
	int stuck_seen;
	int refusals_seen;
	int door_changes_seen;
	int reg_settings;
	int burst_left;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advances the tracker copy by one tick and returns the report it yields.
	function automatic door_report_t track_door_tick(input tick_t t);
		door_report_t r;
		logic [2:0]   prior;
		logic [2:0]   target;
		logic         new_lock;
		logic         take;
		r = '0;
		prior = trk_door;
		take = 1'b0;

		if (trk_since != gdpt_pkg::SINCE_MAX) begin
			trk_since = trk_since + 1'b1;
		end

		// Sensor rule, then the bounce filter.
		target = trk_door;
		if (trk_door != gdpt_pkg::DOOR_CODE_OPENING && !t.front && t.rear) begin
			target = gdpt_pkg::DOOR_CODE_CLOSED;
		end else if (trk_door != gdpt_pkg::DOOR_CODE_CLOSING && t.front && !t.rear) begin
			target = gdpt_pkg::DOOR_CODE_OPEN;
		end else if (trk_door != gdpt_pkg::DOOR_CODE_STUCK && t.front && t.rear) begin
			if (trk_door == gdpt_pkg::DOOR_CODE_OPEN) begin
				target = gdpt_pkg::DOOR_CODE_CLOSING;
			end else if (trk_door == gdpt_pkg::DOOR_CODE_CLOSED) begin
				target = gdpt_pkg::DOOR_CODE_OPENING;
			end
		end
		if (target != trk_door && trk_since > {1'b0, bounce_ticks}) begin
			trk_door = target;
			trk_since = '0;
		end

		// A move that runs too long leaves the door stuck.
		if ((trk_door == gdpt_pkg::DOOR_CODE_CLOSING ||
				trk_door == gdpt_pkg::DOOR_CODE_OPENING) &&
				trk_since > {1'b0, max_move_ticks}) begin
			trk_door = gdpt_pkg::DOOR_CODE_STUCK;
			r.stuck_alarm = 1'b1;
		end

		new_lock = t.armed || !t.home;
		if (new_lock != trk_lock) begin
			trk_lock = new_lock;
			r.lock_changed = 1'b1;
		end

		if (trk_pulse != '0) begin
			trk_pulse = trk_pulse - 1'b1;
		end

		// Commands are judged against the updated door and lock.
		case (t.cmd)
			gdpt_pkg::CMD_OPEN: begin
				if (trk_door != gdpt_pkg::DOOR_CODE_OPEN) begin
					if (trk_lock) begin
						r.open_refused = 1'b1;
					end else begin
						take = 1'b1;
					end
				end
			end
			gdpt_pkg::CMD_CLOSE:    take = (trk_door != gdpt_pkg::DOOR_CODE_CLOSED);
			gdpt_pkg::CMD_STOP:     take = (trk_door == gdpt_pkg::DOOR_CODE_OPENING) ||
				(trk_door == gdpt_pkg::DOOR_CODE_CLOSING);
			gdpt_pkg::CMD_OVERRIDE: take = 1'b1;
			default:                take = 1'b0;
		endcase
		if (take) begin
			trk_pulse = pulse_ticks;
		end

		r.relay = (trk_pulse != '0);
		r.door = trk_door;
		r.state_changed = (trk_door != prior);
		r.locked = trk_lock;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [2:0] want,
			input logic [2:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, seen);
			error_count++;
		end
	endfunction

	// Sends one tick; the sender works in bursts separated by random gaps.
	task automatic send_tick(input logic front, input logic rear, input logic [2:0] cmd,
			input logic armed, input logic home);
		tick_t t;
		int    gap;
		t = {front, rear, cmd, armed, home};
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		tick_ch.valid <= 1'b1;
		tick_ch.closed_limit <= front;
		tick_ch.open_limit <= rear;
		tick_ch.command <= cmd;
		tick_ch.armed <= armed;
		tick_ch.anyone_home <= home;
		do @(posedge clk); while (!tick_ch.ready);
		door_reports_due.push_back(track_door_tick(t));
		ticks_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Waits until every report has arrived and the block has settled.
	task automatic drain_reports();
		tick_ch.valid <= 1'b0;
		while (door_reports_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers back to back; only called while idle.
	task automatic program_regs(input logic [gdpt_pkg::CFG_WIDTH-1:0] bounce,
			input logic [gdpt_pkg::CFG_WIDTH-1:0] max_move,
			input logic [gdpt_pkg::CFG_WIDTH-1:0] pulse);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= gdpt_pkg::REG_BOUNCE_MS;
		wr_data <= bounce;
		@(negedge clk);
		wr_index <= gdpt_pkg::REG_MAX_MOVE_MS;
		wr_data <= max_move;
		@(negedge clk);
		wr_index <= gdpt_pkg::REG_PULSE_MS;
		wr_data <= pulse;
		@(negedge clk);
		wr_en <= 1'b0;
		bounce_ticks = bounce;
		max_move_ticks = max_move;
		pulse_ticks = pulse;
		reg_settings++;
	endtask

	// Reset settings: open refused while armed or nobody home, command gating
	// on a closed door, unknown command codes and sensor changes held off by
	// the long bounce time.
	task automatic test_command_gating();
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_NONE, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_OPEN, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_OPEN, 1'b0, 1'b0);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_OPEN, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_CLOSE, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_STOP, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_OVERRIDE, 1'b1, 1'b0);
		for (int c = int'(gdpt_pkg::CMD_OVERRIDE) + 1; c < 8; c++) begin
			send_tick(1'b1, 1'b1, 3'(c), 1'b0, 1'b1);
		end
		send_tick(1'b0, 1'b0, gdpt_pkg::CMD_NONE, 1'b1, 1'b1);
		drain_reports();
	endtask

	// Zero bounce time and a one-tick pulse: a full open and close cycle,
	// stop during a move, and sensor states that the current move blocks.
	task automatic test_door_moves();
		program_regs('0, '1, 16'd1);
		send_tick(1'b1, 1'b1, gdpt_pkg::CMD_STOP, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, gdpt_pkg::CMD_OPEN, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, gdpt_pkg::CMD_CLOSE, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		drain_reports();
	endtask

	// Zero move time makes the door stuck one tick into a move; a zero pulse
	// length gives no relay pulse for accepted commands.
	task automatic test_stuck_and_zero_pulse();
		program_regs('0, '0, '0);
		send_tick(1'b1, 1'b1, gdpt_pkg::CMD_OVERRIDE, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, gdpt_pkg::CMD_STOP, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, gdpt_pkg::CMD_NONE, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, gdpt_pkg::CMD_OPEN, 1'b0, 1'b1);
		drain_reports();
	endtask

	// Mostly well-formed door cycles (closed, moving, open, moving) with
	// random hold times, some sensor noise, commands and lock changes.
	task automatic run_door_cycles(input int count);
		int         hold;
		int         step;
		logic [1:0] sensors;
		logic [2:0] cmd;
		logic       armed;
		logic       home;
		hold = 0;
		step = $urandom_range(0, 3);
		sensors = 2'b01;
		armed = 1'($urandom_range(0, 1));
		home = 1'($urandom_range(0, 1));
		repeat (count) begin
			if (hold == 0) begin
				hold = $urandom_range(1, 12);
				if ($urandom_range(0, 99) < 80) begin
					step = (step + 1) % 4;
					sensors = (step == 0) ? 2'b01 : (step == 2) ? 2'b10 : 2'b11;
				end else begin
					sensors = 2'($urandom_range(0, 3));
				end
			end
			hold--;
			if ($urandom_range(0, 9) == 0) begin
				armed = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0) begin
				home = 1'($urandom_range(0, 1));
			end
			cmd = ($urandom_range(0, 99) < 55) ? gdpt_pkg::CMD_NONE :
				3'($urandom_range(1, 7));
			send_tick(sensors[1], sensors[0], cmd, armed, home);
		end
	endtask

	// Random traffic under a series of register settings, extremes included.
	task automatic test_random_traffic();
		logic [gdpt_pkg::CFG_WIDTH-1:0] bounce;
		logic [gdpt_pkg::CFG_WIDTH-1:0] max_move;
		logic [gdpt_pkg::CFG_WIDTH-1:0] pulse;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					bounce = '0; max_move = '0; pulse = 16'd1;
				end
				1: begin
					bounce = 16'd2; max_move = 16'd15; pulse = 16'd4;
				end
				2: begin
					bounce = '1; max_move = '1; pulse = '1;
				end
				3: begin
					bounce = 16'd1; max_move = '1; pulse = '0;
				end
				6: begin
					bounce = '0; max_move = 16'd8; pulse = 16'd2;
				end
				default: begin
					bounce = 16'($urandom_range(0, 6));
					max_move = 16'($urandom_range(0, 30));
					pulse = 16'($urandom_range(0, 8));
				end
			endcase
			program_regs(bounce, max_move, pulse);
			run_door_cycles(RANDOM_PHASE_TICKS);
			drain_reports();
		end
	endtask

	// Result receiver; it switches at random between three stall patterns: none, short stalls and rare long stalls.
	initial begin : report_sink
		int cycle;
		int rx_mode;
		int stall_left;
		cycle = 0;
		rx_mode = 0;
		stall_left = 0;
		report_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cycle % 128 == 0) begin
				rx_mode = $urandom_range(0, 2);
			end
			cycle++;
			if (stall_left > 0) begin
				report_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				report_ch.ready <= 1'b1;
				if (rx_mode == 1 && $urandom_range(0, 9) < 3) begin
					stall_left = $urandom_range(1, 3);
				end else if (rx_mode == 2 && $urandom_range(0, 49) == 0) begin
					stall_left = $urandom_range(5, 30);
				end
			end
		end
	end

	// Compares each accepted report with the oldest one due.
	always @(posedge clk) begin : check_reports
		door_report_t seen;
		door_report_t want;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			seen = {report_ch.relay, report_ch.door, report_ch.state_changed,
				report_ch.stuck_alarm, report_ch.locked, report_ch.lock_changed,
				report_ch.open_refused};
			if (door_reports_due.size() == 0) begin
				$error("result transaction with none due: door %0d", seen.door);
				error_count++;
			end else begin
				want = door_reports_due.pop_front();
				compare_field("relay", 3'(want.relay), 3'(seen.relay));
				compare_field("door", want.door, seen.door);
				compare_field("state_changed", 3'(want.state_changed),
					3'(seen.state_changed));
				compare_field("stuck_alarm", 3'(want.stuck_alarm), 3'(seen.stuck_alarm));
				compare_field("locked", 3'(want.locked), 3'(seen.locked));
				compare_field("lock_changed", 3'(want.lock_changed), 3'(seen.lock_changed));
				compare_field("open_refused", 3'(want.open_refused), 3'(seen.open_refused));
				reports_checked++;
				stuck_seen += want.stuck_alarm;
				refusals_seen += want.open_refused;
				door_changes_seen += want.state_changed;
			end
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) ||
				(report_ch.valid && report_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
			$display("[garage_door_position_tracker_top] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = gdpt_pkg::REG_BOUNCE_MS;
		wr_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.closed_limit = 1'b1;
		tick_ch.open_limit = 1'b1;
		tick_ch.command = gdpt_pkg::CMD_NONE;
		tick_ch.armed = 1'b0;
		tick_ch.anyone_home = 1'b0;
		trk_door = gdpt_pkg::DOOR_CODE_CLOSED;
		trk_since = '0;
		trk_lock = 1'b1;
		trk_pulse = '0;
		bounce_ticks = gdpt_pkg::BOUNCE_MS_RESET;
		max_move_ticks = gdpt_pkg::MAX_MOVE_MS_RESET;
		pulse_ticks = gdpt_pkg::PULSE_MS_RESET;
		error_count = 0;
		ticks_sent = 0;
		reports_checked = 0;
		stuck_seen = 0;
		refusals_seen = 0;
		door_changes_seen = 0;
		reg_settings = 1;
		burst_left = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_command_gating();
		test_door_moves();
		test_stuck_and_zero_pulse();
		test_random_traffic();
		drain_reports();

		if (door_reports_due.size() != 0) begin
			$error("%0d result transactions never arrived", door_reports_due.size());
			error_count++;
		end
		$display("Ran %0d ticks under %0d register settings, %0d results checked.",
			ticks_sent, reg_settings, reports_checked);
		$display("Door changes %0d, stuck alarms %0d, refused opens %0d, mismatches %0d.",
			door_changes_seen, stuck_seen, refusals_seen, error_count);
		if (error_count == 0) begin
			$display("[garage_door_position_tracker_top] OK");
		end else begin
			$display("[garage_door_position_tracker_top] ERROR");
		end
		$finish;
	end

endmodule

// File: garage_door_position_tracker_top.f
hdl/gdpt_pkg.sv
hdl/gdpt_if.sv
hdl/garage_door_position_tracker_top.sv
test/tb.sv
